>>> rtl/core/cap_pkg.sv
`timescale 1ns / 1ps

package cap_pkg;

  // Field and datapath widths
  localparam int GainW  = 16;
  localparam int AngW   = 16;
  localparam int ErrW   = AngW + 1;
  localparam int DiffW  = ErrW + 1;
  localparam int DerW   = 26;
  localparam int IntW   = 32;
  localparam int MulAW  = GainW + 1;
  localparam int ProdW  = MulAW + IntW;
  localparam int AccW   = 60;
  localparam int ResW   = AccW - 24;
  localparam int DriveW = 24;
  localparam int CfgAddrW = 3;
  localparam int StageW = 2;

  // Configuration register indexes
  localparam logic [CfgAddrW-1:0] CFG_OUTER_KP = 3'd0;
  localparam logic [CfgAddrW-1:0] CFG_OUTER_KI = 3'd1;
  localparam logic [CfgAddrW-1:0] CFG_OUTER_KD = 3'd2;
  localparam logic [CfgAddrW-1:0] CFG_INNER_KP = 3'd3;
  localparam logic [CfgAddrW-1:0] CFG_INNER_KI = 3'd4;
  localparam logic [CfgAddrW-1:0] CFG_INNER_KD = 3'd5;
  localparam logic [CfgAddrW-1:0] CFG_FLY_EN   = 3'd6;

  // Reset values of the gains
  localparam logic [GainW-1:0] RST_OUTER_KP = 16'd256;
  localparam logic [GainW-1:0] RST_OUTER_KI = 16'd0;
  localparam logic [GainW-1:0] RST_OUTER_KD = 16'd0;
  localparam logic [GainW-1:0] RST_INNER_KP = 16'd179;
  localparam logic [GainW-1:0] RST_INNER_KI = 16'd256;
  localparam logic [GainW-1:0] RST_INNER_KD = 16'd77;

  // dt = 0.005 in Q0.16, derivative scale 1/dt, integral clamp 300.0 in Q.20
  localparam logic signed [MulAW-1:0] DT_Q16      = 17'sd328;
  localparam logic signed [MulAW-1:0] DERIV_SCALE = 17'sd200;
  localparam logic signed [IntW-1:0]  INTEG_LIM   = 32'sd314572800;
  localparam logic signed [IntW-1:0]  INTEG_NEG   = -32'sd314572800;

  // Stage indexes
  localparam logic [StageW-1:0] STG_OUTER_ROLL  = 2'd0;
  localparam logic [StageW-1:0] STG_OUTER_PITCH = 2'd1;
  localparam logic [StageW-1:0] STG_INNER_ROLL  = 2'd2;
  localparam logic [StageW-1:0] STG_INNER_PITCH = 2'd3;

  typedef struct packed {
    logic signed [AngW-1:0] roll_target;
    logic signed [AngW-1:0] pitch_target;
    logic signed [AngW-1:0] roll_angle;
    logic signed [AngW-1:0] pitch_angle;
    logic signed [AngW-1:0] roll_rate;
    logic signed [AngW-1:0] pitch_rate;
    logic [GainW-1:0]       throttle;
  } cap_in_t;

  typedef struct packed {
    logic signed [DriveW-1:0] roll_drive;
    logic signed [DriveW-1:0] pitch_drive;
    logic                     motors_on;
  } cap_out_t;

  // Steps of one PID stage on the shared multiplier
  typedef enum logic [2:0] {
    PH_ERR,     // error, difference, integral reset test
    PH_MUL_DT,  // e * dt
    PH_MUL_D,   // diff * 200, integral update
    PH_MUL_P,   // kp * e, latch derivative
    PH_MUL_I,   // ki * I, start sum
    PH_MUL_K,   // kd * d, add integral term
    PH_ACC,     // add derivative term
    PH_DONE     // shift and saturate
  } cap_phase_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } cap_state_t;

  typedef struct packed {
    logic       run;
    cap_phase_t phase;
  } cap_ctrl_t;

endpackage

>>> rtl/core/cap_dp.sv
`timescale 1ns / 1ps

module cap_dp (
  input  logic                                clk,
  input  cap_pkg::cap_ctrl_t                  ctrl,
  input  logic signed [cap_pkg::AngW-1:0]     tgt,
  input  logic signed [cap_pkg::AngW-1:0]     meas,
  input  logic signed [cap_pkg::ErrW-1:0]     prev,
  input  logic signed [cap_pkg::IntW-1:0]     integ,
  input  logic [cap_pkg::GainW-1:0]           thr,
  input  logic [cap_pkg::GainW-1:0]           kp,
  input  logic [cap_pkg::GainW-1:0]           ki,
  input  logic [cap_pkg::GainW-1:0]           kd,
  output logic signed [cap_pkg::ErrW-1:0]     err,
  output logic signed [cap_pkg::IntW-1:0]     integ_upd,
  output logic signed [cap_pkg::AngW-1:0]     res_rate,
  output logic signed [cap_pkg::DriveW-1:0]   res_drive
);
  import cap_pkg::*;

  localparam logic signed [ResW-1:0]   RATE_MAX  = ResW'(32767);
  localparam logic signed [ResW-1:0]   RATE_MIN  = ResW'(-32768);
  localparam logic signed [ResW-1:0]   DRIVE_MAX = ResW'(8388607);
  localparam logic signed [ResW-1:0]   DRIVE_MIN = ResW'(-8388608);
  localparam logic signed [IntW:0]     ISUM_MAX  = {INTEG_LIM[IntW-1], INTEG_LIM};
  localparam logic signed [IntW:0]     ISUM_MIN  = {INTEG_NEG[IntW-1], INTEG_NEG};

  logic signed [ErrW-1:0]  e_r;
  logic signed [DiffW-1:0] diff_r;
  logic                    clr_r;
  logic signed [DerW-1:0]  d_r;
  logic signed [ProdW-1:0] prod_r;
  logic signed [AccW-1:0]  acc_r;

  logic signed [DiffW-1:0] diff_c;
  logic signed [IntW:0]    integ_ext;
  logic [IntW:0]           mag_c;
  logic                    clr_c;
  logic signed [MulAW-1:0] mul_a;
  logic signed [IntW-1:0]  mul_b;
  logic signed [ProdW-1:0] mul_p;
  logic signed [IntW:0]    isum;
  logic signed [IntW-1:0]  iclamp;
  logic signed [AccW-1:0]  prod_ext;
  logic signed [AccW-1:0]  acc_nxt;
  logic signed [ResW-1:0]  res;

  // error and integral reset test
  assign err       = {tgt[AngW-1], tgt} - {meas[AngW-1], meas};
  assign diff_c    = {err[ErrW-1], err} - {prev[ErrW-1], prev};
  assign integ_ext = {integ[IntW-1], integ};
  assign mag_c     = integ_ext[IntW] ? ((IntW+1)'(0) - integ_ext) : integ_ext;
  assign clr_c     = !({3'b000, mag_c} < {thr, 20'd0});

  // integral step, clamp to +-300
  assign isum = integ_ext + {{(IntW+1-DerW){prod_r[DerW-1]}}, prod_r[DerW-1:0]};
  always_comb begin
    if (isum > ISUM_MAX) begin
      iclamp = INTEG_LIM;
    end else if (isum < ISUM_MIN) begin
      iclamp = INTEG_NEG;
    end else begin
      iclamp = isum[IntW-1:0];
    end
  end
  assign integ_upd = clr_r ? '0 : iclamp;

  // shared multiplier operand select
  always_comb begin
    case (ctrl.phase)
      PH_MUL_DT: begin
        mul_a = DT_Q16;
        mul_b = {{(IntW-ErrW){e_r[ErrW-1]}}, e_r};
      end
      PH_MUL_D: begin
        mul_a = DERIV_SCALE;
        mul_b = {{(IntW-DiffW){diff_r[DiffW-1]}}, diff_r};
      end
      PH_MUL_P: begin
        mul_a = {1'b0, kp};
        mul_b = {{(IntW-ErrW){e_r[ErrW-1]}}, e_r};
      end
      PH_MUL_I: begin
        mul_a = {1'b0, ki};
        mul_b = integ;
      end
      PH_MUL_K: begin
        mul_a = {1'b0, kd};
        mul_b = {{(IntW-DerW){d_r[DerW-1]}}, d_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p    = ProdW'(mul_a) * ProdW'(mul_b);
  assign prod_ext = {{(AccW-ProdW){prod_r[ProdW-1]}}, prod_r};

  // Q.28 sum: P and D terms carry an extra 2^16
  always_comb begin
    case (ctrl.phase)
      PH_MUL_I: acc_nxt = prod_ext <<< 16;
      PH_MUL_K: acc_nxt = acc_r + prod_ext;
      PH_ACC:   acc_nxt = acc_r + (prod_ext <<< 16);
      default:  acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.run) begin
      prod_r <= mul_p;
      acc_r  <= acc_nxt;
      case (ctrl.phase)
        PH_ERR: begin
          e_r    <= err;
          diff_r <= diff_c;
          clr_r  <= clr_c;
        end
        PH_MUL_P: begin
          d_r <= prod_r[DerW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // floor shift by 24, then saturate
  assign res = acc_r[AccW-1:24];

  always_comb begin
    if (res > RATE_MAX) begin
      res_rate = RATE_MAX[AngW-1:0];
    end else if (res < RATE_MIN) begin
      res_rate = RATE_MIN[AngW-1:0];
    end else begin
      res_rate = res[AngW-1:0];
    end
    if (res > DRIVE_MAX) begin
      res_drive = DRIVE_MAX[DriveW-1:0];
    end else if (res < DRIVE_MIN) begin
      res_drive = DRIVE_MIN[DriveW-1:0];
    end else begin
      res_drive = res[DriveW-1:0];
    end
  end

endmodule

>>> rtl/core/cascaded_attitude_pid_top.sv
`timescale 1ns / 1ps

// Channel   Handshake              Word
// in_       in_valid / in_ready    cap_in_t: targets, angles, rates, throttle
// out_      out_valid / out_ready  cap_out_t: roll/pitch drive, motors_on
// cfg_      cfg_we                 cfg_addr selects register, cfg_wdata[15:0]
//
// After acceptance, one word runs as four PID stages of 8 steps each on
// the single shared 17x32 multiplier, and the result goes to the output
// register after that. in_ready is high only while the sequencer is idle.
// A finished word that waits for out_ready does not block the next input;
// the last stage holds only if the output register is still full.
// Reset (rst_n low, synchronous) clears gains to defaults and all PID state.
module cascaded_attitude_pid_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  cap_pkg::cap_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output cap_pkg::cap_out_t                 out_data,
  input  logic                              cfg_we,
  input  logic [cap_pkg::CfgAddrW-1:0]      cfg_addr,
  input  logic [cap_pkg::GainW-1:0]         cfg_wdata
);
  import cap_pkg::*;

  cap_state_t           state_r, state_nxt;
  cap_phase_t           phase_r, phase_nxt;
  logic [StageW-1:0]    stage_r, stage_nxt;
  cap_ctrl_t            ctrl;
  logic                 load_out;
  logic                 out_free;

  cap_in_t              in_r;
  logic [GainW-1:0]     outer_kp_r, outer_ki_r, outer_kd_r;
  logic [GainW-1:0]     inner_kp_r, inner_ki_r, inner_kd_r;
  logic                 fly_r;

  // per-stage state: 0 outer roll, 1 outer pitch, 2 inner roll, 3 inner pitch
  logic signed [ErrW-1:0]   prev_r  [4];
  logic signed [IntW-1:0]   integ_r [4];

  logic signed [AngW-1:0]   ro_r, po_r;
  logic signed [DriveW-1:0] ri_r;

  logic                     out_valid_r;
  cap_out_t                 out_data_r;

  logic signed [AngW-1:0]   tgt, meas;
  logic [GainW-1:0]         kp, ki, kd;
  logic signed [ErrW-1:0]   err;
  logic signed [IntW-1:0]   integ_upd;
  logic signed [AngW-1:0]   res_rate;
  logic signed [DriveW-1:0] res_drive;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  assign ctrl.run   = (state_r == ST_RUN);
  assign ctrl.phase = phase_r;

  // ---- config registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outer_kp_r <= RST_OUTER_KP;
      outer_ki_r <= RST_OUTER_KI;
      outer_kd_r <= RST_OUTER_KD;
      inner_kp_r <= RST_INNER_KP;
      inner_ki_r <= RST_INNER_KI;
      inner_kd_r <= RST_INNER_KD;
      fly_r      <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_OUTER_KP: outer_kp_r <= cfg_wdata;
        CFG_OUTER_KI: outer_ki_r <= cfg_wdata;
        CFG_OUTER_KD: outer_kd_r <= cfg_wdata;
        CFG_INNER_KP: inner_kp_r <= cfg_wdata;
        CFG_INNER_KI: inner_ki_r <= cfg_wdata;
        CFG_INNER_KD: inner_kd_r <= cfg_wdata;
        CFG_FLY_EN:   fly_r      <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_ERR;
      stage_r <= STG_OUTER_ROLL;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      stage_r <= stage_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    stage_nxt = stage_r;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        phase_nxt = PH_ERR;
        stage_nxt = STG_OUTER_ROLL;
        if (in_valid) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (phase_r != PH_DONE) begin
          phase_nxt = cap_phase_t'(3'(phase_r) + 3'd1);
        end else if (stage_r != STG_INNER_PITCH) begin
          phase_nxt = PH_ERR;
          stage_nxt = stage_r + 2'd1;
        end else if (out_free) begin
          // last stage done: hand the word to the output register
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
          phase_nxt = PH_ERR;
          stage_nxt = STG_OUTER_ROLL;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  // ---- operand select for the current stage ----
  always_comb begin
    case (stage_r)
      STG_OUTER_ROLL: begin
        tgt  = in_r.roll_target;
        meas = in_r.roll_angle;
      end
      STG_OUTER_PITCH: begin
        tgt  = in_r.pitch_target;
        meas = in_r.pitch_angle;
      end
      STG_INNER_ROLL: begin
        tgt  = ro_r;
        meas = in_r.roll_rate;
      end
      default: begin
        tgt  = po_r;
        meas = in_r.pitch_rate;
      end
    endcase
  end

  // outer stages share one gain set, inner stages the other
  assign kp = stage_r[1] ? inner_kp_r : outer_kp_r;
  assign ki = stage_r[1] ? inner_ki_r : outer_ki_r;
  assign kd = stage_r[1] ? inner_kd_r : outer_kd_r;

  cap_dp u_dp (
    .clk       (clk),
    .ctrl      (ctrl),
    .tgt       (tgt),
    .meas      (meas),
    .prev      (prev_r[stage_r]),
    .integ     (integ_r[stage_r]),
    .thr       (in_r.throttle),
    .kp        (kp),
    .ki        (ki),
    .kd        (kd),
    .err       (err),
    .integ_upd (integ_upd),
    .res_rate  (res_rate),
    .res_drive (res_drive)
  );

  // ---- PID state ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        prev_r[i]  <= '0;
        integ_r[i] <= '0;
      end
    end else if (ctrl.run) begin
      if (phase_r == PH_ERR) begin
        prev_r[stage_r] <= err;
      end
      if (phase_r == PH_MUL_D) begin
        integ_r[stage_r] <= integ_upd;
      end
    end
  end

  // stage results; outer ones feed the inner targets
  always_ff @(posedge clk) begin
    if (ctrl.run && (phase_r == PH_DONE)) begin
      case (stage_r)
        STG_OUTER_ROLL:  ro_r <= res_rate;
        STG_OUTER_PITCH: po_r <= res_rate;
        STG_INNER_ROLL:  ri_r <= res_drive;
        default: begin
        end
      endcase
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r.roll_drive  <= fly_r ? ri_r : '0;
      out_data_r.pitch_drive <= fly_r ? res_drive : '0;
      out_data_r.motors_on   <= fly_r;
    end
  end

`ifndef ASSERT_OFF
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_RUN && stage_r == STG_OUTER_ROLL
                             && phase_r == PH_ERR)
    else $error("sequencer did not start at outer roll");

  a_load_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(stage_r) == STG_INNER_PITCH && $past(phase_r) == PH_DONE)
    else $error("result word loaded before the last stage finished");

  a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.motors_on |->
      out_data_r.roll_drive == '0 && out_data_r.pitch_drive == '0)
    else $error("drive not zero with motors off");

  a_integ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    integ_r[stage_r] <= INTEG_LIM && integ_r[stage_r] >= INTEG_NEG)
    else $error("integral outside clamp");
`endif

endmodule

>>> dv/cascaded_attitude_pid_top_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the cascaded roll/pitch attitude controller.
module cascaded_attitude_pid_top_tb;
  import cap_pkg::*;

  // Register index with no register behind it: writes must be dropped
  localparam logic [CfgAddrW-1:0] CFG_NONE = 3'd7;
  localparam logic [CfgAddrW-1:0] GAIN_REGS [6] = '{
    CFG_OUTER_KP, CFG_OUTER_KI, CFG_OUTER_KD, CFG_INNER_KP, CFG_INNER_KI, CFG_INNER_KD
  };

  localparam logic signed [DriveW-1:0] DRIVE_TOP = 24'sh7FFFFF;
  localparam logic signed [DriveW-1:0] DRIVE_BOT = 24'sh800000;

  // Controller arithmetic: dt in Q0.16, 1/dt, integral bound 300.0 in Q.20
  localparam longint DT_STEP   = 328;
  localparam longint DIFF_GAIN = 200;
  localparam longint INTEG_CAP = 64'd300 << 20;

  localparam int SEGMENTS    = 8;
  localparam int SEG_WORDS   = 92;
  localparam int TAIL_CYCLES = 80;    // idle run after the last drive word is back
  localparam int STALL_LIMIT = 2000;  // cycles with no handshake and no register write

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  // One row of the directed table: either a word to send or a register write.
  // Rows marked fixed carry their expected drive word; the rest use the predictor.
  typedef struct {
    row_kind_t             kind;
    cap_in_t               word;
    logic                  fixed;
    cap_out_t              want;
    logic [CfgAddrW-1:0]   addr;
    logic [GainW-1:0]      data;
  } plan_row_t;

  localparam cap_out_t HOVER_ZERO = '{24'sd0, 24'sd0, 1'b1};
  localparam cap_out_t MOTORS_OFF = '0;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  cap_in_t             in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  cap_out_t            out_data;
  logic                cfg_we    = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr  = '0;
  logic [GainW-1:0]    cfg_wdata = '0;

  // Predictor copy of the gains, fly flag and per-stage state
  logic [GainW-1:0]       gain_okp, gain_oki, gain_okd, gain_ikp, gain_iki, gain_ikd;
  logic                   fly_on;
  logic signed [ErrW-1:0] last_err [4];
  logic signed [IntW-1:0] integ_acc [4];

  cap_out_t drive_due [$];   // expected drive words, oldest first
  int       miss_count     = 0;
  int       send_idle_pct  = 0;
  int       recv_stall_pct = 0;
  int       quiet_cycles   = 0;

  cascaded_attitude_pid_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // One PID stage: updates that stage's error and integral, returns Q.4 output
  function automatic longint pid_stage_out(int s, longint tgt, longint meas,
                                           logic [GainW-1:0] kp, logic [GainW-1:0] ki,
                                           logic [GainW-1:0] kd, longint thr);
    longint err, diff, acc, mag, sum, kp_l, ki_l, kd_l;
    kp_l = longint'(kp);
    ki_l = longint'(ki);
    kd_l = longint'(kd);
    err  = tgt - meas;
    diff = (err - longint'(last_err[s])) * DIFF_GAIN;
    acc  = longint'(integ_acc[s]);
    mag  = (acc < 0) ? -acc : acc;
    last_err[s] = err[ErrW-1:0];
    // integral runs only while its magnitude is below the throttle
    if (mag < (thr << 20))
      acc = clip(acc + err * DT_STEP, -INTEG_CAP, INTEG_CAP);
    else
      acc = 0;
    integ_acc[s] = acc[IntW-1:0];
    sum = kp_l * err * 65536 + ki_l * acc + kd_l * diff * 65536;
    return sum >>> 24;   // floor towards minus infinity
  endfunction

  function automatic cap_out_t predict_drive(cap_in_t w);
    cap_out_t r;
    longint   thr, roll_rt, pitch_rt, roll_dr, pitch_dr;
    thr      = longint'(w.throttle);
    roll_rt  = pid_stage_out(int'(STG_OUTER_ROLL), longint'(w.roll_target),
                             longint'(w.roll_angle), gain_okp, gain_oki, gain_okd, thr);
    pitch_rt = pid_stage_out(int'(STG_OUTER_PITCH), longint'(w.pitch_target),
                             longint'(w.pitch_angle), gain_okp, gain_oki, gain_okd, thr);
    // outer outputs become inner rate targets, limited to the rate range
    roll_rt  = clip(roll_rt, -32768, 32767);
    pitch_rt = clip(pitch_rt, -32768, 32767);
    roll_dr  = pid_stage_out(int'(STG_INNER_ROLL), roll_rt, longint'(w.roll_rate),
                             gain_ikp, gain_iki, gain_ikd, thr);
    pitch_dr = pid_stage_out(int'(STG_INNER_PITCH), pitch_rt, longint'(w.pitch_rate),
                             gain_ikp, gain_iki, gain_ikd, thr);
    roll_dr  = clip(roll_dr, -8388608, 8388607);
    pitch_dr = clip(pitch_dr, -8388608, 8388607);
    r = '0;
    if (fly_on) begin
      r.roll_drive  = roll_dr[DriveW-1:0];
      r.pitch_drive = pitch_dr[DriveW-1:0];
      r.motors_on   = 1'b1;
    end
    return r;
  endfunction

  function automatic logic signed [AngW-1:0] rand_s16(int unsigned span);
    return AngW'($urandom_range(2 * span - 1)) - AngW'(span);
  endfunction

  // Register write; cfg_we is dropped by whoever drives next
  task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [GainW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_OUTER_KP: gain_okp = val;
      CFG_OUTER_KI: gain_oki = val;
      CFG_OUTER_KD: gain_okd = val;
      CFG_INNER_KP: gain_ikp = val;
      CFG_INNER_KI: gain_iki = val;
      CFG_INNER_KD: gain_ikd = val;
      CFG_FLY_EN:   fly_on   = val[0];
      default: ;
    endcase
  endtask

  // Offer one word, hold it until taken, then log what it should produce
  task automatic send_word(input cap_in_t w, input logic fixed, input cap_out_t want);
    cap_out_t calc;
    cfg_we <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    calc = predict_drive(w);
    drive_due.push_back(fixed ? want : calc);
  endtask

  // Block is idle once every expected drive word has come back
  task automatic drain_words();
    in_valid <= 1'b0;
    while (drive_due.size() != 0) @(posedge clk);
  endtask

  // Result side: random back-pressure and field-by-field compare
  always @(posedge clk) begin
    cap_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (drive_due.size() == 0) begin
        $display("%0t unexpected drive word: expected none, got %h", $time, out_data);
        miss_count++;
      end else begin
        want = drive_due.pop_front();
        if (out_data.roll_drive !== want.roll_drive) begin
          $display("%0t roll_drive: expected %0d, got %0d", $time, want.roll_drive,
                   out_data.roll_drive);
          miss_count++;
        end
        if (out_data.pitch_drive !== want.pitch_drive) begin
          $display("%0t pitch_drive: expected %0d, got %0d", $time, want.pitch_drive,
                   out_data.pitch_drive);
          miss_count++;
        end
        if (out_data.motors_on !== want.motors_on) begin
          $display("%0t motors_on: expected %0b, got %0b", $time, want.motors_on,
                   out_data.motors_on);
          miss_count++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: any handshake or register write counts as progress
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    plan_row_t         plan [30];
    cap_in_t           held, w;
    logic [127:0]      noise;
    logic [GainW-1:0]  gain;
    logic              cfg_quiet;
    int unsigned       span;
    int                sent, run_len;

    plan = '{
      // straight out of reset, nothing moves
      '{ROW_WORD, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0},
        1'b1, HOVER_ZERO, CFG_NONE, '0},
      '{ROW_WORD, '{16'sd160, -16'sd80, 16'sd16, 16'sd0, -16'sd32, 16'sd48, 16'd50},
        1'b0, '0, CFG_NONE, '0},
      '{ROW_WORD, '{16'sh7FFF, 16'sh8000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'hFFFF},
        1'b0, '0, CFG_NONE, '0},
      // throttle of one: integral gets one step, then is cleared
      '{ROW_WORD, '{16'sd16000, -16'sd12000, -16'sd16000, 16'sd12000, 16'sd0, 16'sd0, 16'd1},
        1'b0, '0, CFG_NONE, '0},
      '{ROW_WORD, '{16'sd16000, -16'sd12000, -16'sd16000, 16'sd12000, 16'sd500, -16'sd500,
        16'd1}, 1'b0, '0, CFG_NONE, '0},
      '{ROW_CFG, '0, 1'b0, '0, CFG_INNER_KP, 16'hFFFF},
      // full-scale errors with zero throttle: both drives pinned at opposite rails
      '{ROW_WORD, '{16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'd0},
        1'b1, '{DRIVE_TOP, DRIVE_BOT, 1'b1}, CFG_NONE, '0},
      '{ROW_WORD, '{16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'd0},
        1'b1, '{DRIVE_BOT, DRIVE_TOP, 1'b1}, CFG_NONE, '0},
      // grounded: loops still run but nothing reaches the motors
      '{ROW_CFG, '0, 1'b0, '0, CFG_FLY_EN, 16'h0000},
      '{ROW_WORD, '{16'sd1234, -16'sd4321, -16'sd999, 16'sd777, 16'sd5555, -16'sd5555,
        16'hFFFF}, 1'b1, MOTORS_OFF, CFG_NONE, '0},
      '{ROW_WORD, '{16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
        16'd300}, 1'b1, MOTORS_OFF, CFG_NONE, '0},
      // write to the empty slot must not touch the fly flag
      '{ROW_CFG, '0, 1'b0, '0, CFG_NONE, 16'hFFFF},
      '{ROW_WORD, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0},
        1'b1, MOTORS_OFF, CFG_NONE, '0},
      '{ROW_CFG, '0, 1'b0, '0, CFG_FLY_EN, 16'h0001},
      '{ROW_CFG, '0, 1'b0, '0, CFG_OUTER_KP, 16'hFFFF},
      '{ROW_CFG, '0, 1'b0, '0, CFG_OUTER_KI, 16'hFFFF},
      '{ROW_CFG, '0, 1'b0, '0, CFG_OUTER_KD, 16'hFFFF},
      '{ROW_CFG, '0, 1'b0, '0, CFG_INNER_KI, 16'hFFFF},
      '{ROW_CFG, '0, 1'b0, '0, CFG_INNER_KD, 16'hFFFF},
      '{ROW_WORD, '{16'sd800, -16'sd800, 16'sd0, 16'sd0, 16'sd100, -16'sd100, 16'd400},
        1'b0, '0, CFG_NONE, '0},
      '{ROW_WORD, '{16'sd800, -16'sd800, 16'sd40, -16'sd40, 16'sd90, -16'sd90, 16'd400},
        1'b0, '0, CFG_NONE, '0},
      '{ROW_WORD, '{16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sd0, 16'sd0, 16'hFFFF},
        1'b0, '0, CFG_NONE, '0},
      '{ROW_WORD, '{-16'sd5, 16'sd5, 16'sd5, -16'sd5, -16'sd1, 16'sd1, 16'd2},
        1'b0, '0, CFG_NONE, '0},
      // all gains zero: every stage output collapses to nothing
      '{ROW_CFG, '0, 1'b0, '0, CFG_OUTER_KP, 16'h0000},
      '{ROW_CFG, '0, 1'b0, '0, CFG_OUTER_KI, 16'h0000},
      '{ROW_CFG, '0, 1'b0, '0, CFG_OUTER_KD, 16'h0000},
      '{ROW_CFG, '0, 1'b0, '0, CFG_INNER_KP, 16'h0000},
      '{ROW_CFG, '0, 1'b0, '0, CFG_INNER_KI, 16'h0000},
      '{ROW_CFG, '0, 1'b0, '0, CFG_INNER_KD, 16'h0000},
      '{ROW_WORD, '{16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sd1, -16'sd1, 16'hFFFF},
        1'b1, HOVER_ZERO, CFG_NONE, '0}
    };

    // reset values of the register file
    gain_okp = 16'd256;
    gain_oki = 16'd0;
    gain_okd = 16'd0;
    gain_ikp = 16'd179;
    gain_iki = 16'd256;
    gain_ikd = 16'd77;
    fly_on   = 1'b1;
    for (int i = 0; i < 4; i++) begin
      last_err[i]  = '0;
      integ_acc[i] = '0;
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table, no idling. Writes wait for the pipe to empty first.
    cfg_quiet = 1'b1;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        if (!cfg_quiet) begin
          drain_words();
          cfg_quiet = 1'b1;
        end
        write_reg(plan[i].addr, plan[i].data);
      end else begin
        cfg_quiet = 1'b0;
        send_word(plan[i].word, plan[i].fixed, plan[i].want);
      end
    end

    // Random segments, each with its own gains and idling pattern
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      drain_words();
      case (seg % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      foreach (GAIN_REGS[r]) begin
        if (seg == 1)
          gain = '1;
        else begin
          case ($urandom_range(3))
            0: gain = '0;
            1: gain = '1;
            2: gain = GainW'($urandom_range(1023));
            default: gain = GainW'($urandom_range(65535));
          endcase
        end
        write_reg(GAIN_REGS[r], gain);
      end
      // only bit 0 of the fly word counts; one segment flies grounded
      write_reg(CFG_FLY_EN, {15'($urandom_range(32767)), seg != 6});

      sent = 0;
      while (sent < SEG_WORDS) begin
        if ($urandom_range(9) < 7) begin
          // held manoeuvre: fixed targets, jittery sensors, so integrals build up,
          // hit the clamp or get cleared by the throttle bound
          case ($urandom_range(2))
            0: span = 32768;
            1: span = 2048;
            default: span = 256;
          endcase
          held.roll_target  = rand_s16(span);
          held.pitch_target = rand_s16(span);
          held.roll_angle   = rand_s16(span);
          held.pitch_angle  = rand_s16(span);
          held.roll_rate    = rand_s16(span);
          held.pitch_rate   = rand_s16(span);
          case ($urandom_range(3))
            0: held.throttle = '0;
            1: held.throttle = GainW'($urandom_range(400, 1));
            2: held.throttle = GainW'($urandom_range(65535, 401));
            default: held.throttle = GainW'($urandom_range(32, 1));
          endcase
          run_len = $urandom_range(48, 5);
          for (int k = 0; k < run_len && sent < SEG_WORDS; k++) begin
            w = held;
            w.roll_angle  = held.roll_angle + rand_s16(64);
            w.pitch_angle = held.pitch_angle + rand_s16(64);
            w.roll_rate   = held.roll_rate + rand_s16(256);
            w.pitch_rate  = held.pitch_rate + rand_s16(256);
            send_word(w, 1'b0, '0);
            sent++;
          end
        end else begin
          // raw noise word, every bit free
          noise = {$urandom(), $urandom(), $urandom(), $urandom()};
          w = noise[$bits(cap_in_t)-1:0];
          send_word(w, 1'b0, '0);
          sent++;
        end
      end
    end

    drain_words();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (miss_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/cap_pkg.sv
rtl/core/cap_dp.sv
rtl/core/cascaded_attitude_pid_top.sv
dv/cascaded_attitude_pid_top_tb.sv
